// ===== hdl/qau_pkg.sv =====
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit package
// Word widths, pipeline depths, operation and status codes shared by the
// unit, its pipelined square root and divider lanes, and its checker.
// ----------------------------------------------------------------------------
package qau_pkg;

   localparam int WORD_W     = 24;
   localparam int FRAC_W     = 20;
   localparam int MAG_W      = WORD_W - 1;
   localparam int KIND_W     = 3;
   localparam int STAT_W     = 2;

   localparam int PROD_W     = 2 * WORD_W;
   localparam int SUM_W      = PROD_W + 2;
   localparam int RND_W      = SUM_W - FRAC_W;
   localparam int SQ_W       = 2 * WORD_W + 1;
   localparam int ROOT_W     = WORD_W + 1;
   localparam int REM_W      = ROOT_W + 2;
   localparam int SQRT_LAT   = ROOT_W + 1;
   localparam int NUM_W      = WORD_W + FRAC_W;
   localparam int Q_W        = WORD_W;
   localparam int DIV_LAT    = Q_W + 1;
   localparam int PIPE_LAT   = 5 + SQRT_LAT + DIV_LAT;

   localparam int IN_DATA_W  = 9 * WORD_W;
   localparam int OUT_BITS   = 4 * WORD_W + MAG_W + STAT_W;
   localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

   typedef enum logic [KIND_W-1:0] {
      KIND_MUL       = 3'd0,
      KIND_ADD       = 3'd1,
      KIND_SUB       = 3'd2,
      KIND_CONJ      = 3'd3,
      KIND_SCALE     = 3'd4,
      KIND_DIV       = 3'd5,
      KIND_NORMALIZE = 3'd6,
      KIND_NORM      = 3'd7
   } kind_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK   = 2'd0,
      STAT_SAT  = 2'd1,
      STAT_ZERO = 2'd2
   } status_type;

endpackage

// ===== hdl/qau_sqrt.sv =====
// ----------------------------------------------------------------------------
// Pipelined rounded square root
// One result bit per stage over the sum of squares, then a rounding stage.
// ----------------------------------------------------------------------------
module qau_sqrt (
   input  logic                       clock,
   input  logic                       ce,
   input  logic [qau_pkg::SQ_W-1:0]   sq,
   output logic [qau_pkg::ROOT_W-1:0] root
);
   import qau_pkg::*;

   logic [2*ROOT_W-1:0] x_ff    [ROOT_W];
   logic [REM_W-1:0]    rem_ff  [ROOT_W];
   logic [ROOT_W-1:0]   root_ff [ROOT_W];
   logic [ROOT_W-1:0]   out_ff;

   for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
      logic [2*ROOT_W-1:0] x_src;
      logic [REM_W-1:0]    rem_src;
      logic [ROOT_W-1:0]   root_src;
      logic [REM_W+1:0]    cur;
      logic [REM_W+1:0]    trial;
      logic [2*ROOT_W-1:0] x_in;
      logic [REM_W-1:0]    rem_in;
      logic [ROOT_W-1:0]   root_in;

      if (i == 0) begin : g_first
         assign x_src    = (2*ROOT_W)'(sq);
         assign rem_src  = '0;
         assign root_src = '0;
      end else begin : g_next
         assign x_src    = x_ff[i-1];
         assign rem_src  = rem_ff[i-1];
         assign root_src = root_ff[i-1];
      end

      always_comb begin
         cur   = {rem_src, x_src[2*ROOT_W-1 -: 2]};
         trial = (REM_W+2)'({root_src, 2'b01});
         x_in  = x_src << 2;
         if (cur >= trial) begin
            rem_in  = REM_W'(cur - trial);
            root_in = {root_src[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = REM_W'(cur);
            root_in = {root_src[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            x_ff[i]    <= x_in;
            rem_ff[i]  <= rem_in;
            root_ff[i] <= root_in;
         end
      end
   end

   // round to nearest
   always_ff @(posedge clock) begin
      if (ce) begin
         if (rem_ff[ROOT_W-1] > REM_W'(root_ff[ROOT_W-1])) begin
            out_ff <= root_ff[ROOT_W-1] + ROOT_W'(1);
         end else begin
            out_ff <= root_ff[ROOT_W-1];
         end
      end
   end

   assign root = out_ff;

endmodule

// ===== hdl/qau_div_lane.sv =====
// ----------------------------------------------------------------------------
// Pipelined divider lane
// Unsigned restoring division, one quotient bit per stage, with an overflow
// check on the high part of the dividend up front.
// ----------------------------------------------------------------------------
module qau_div_lane (
   input  logic                       clock,
   input  logic                       ce,
   input  logic [qau_pkg::NUM_W-1:0]  num,
   input  logic [qau_pkg::ROOT_W-1:0] den,
   output logic [qau_pkg::Q_W-1:0]    quo,
   output logic                       ovf
);
   import qau_pkg::*;

   logic [ROOT_W-1:0] rem_ff [DIV_LAT];
   logic [ROOT_W-1:0] den_ff [DIV_LAT];
   logic [Q_W-1:0]    lo_ff  [DIV_LAT];
   logic [Q_W-1:0]    q_ff   [DIV_LAT];
   logic              ovf_ff [DIV_LAT];

   always_ff @(posedge clock) begin
      if (ce) begin
         rem_ff[0] <= ROOT_W'(num[NUM_W-1:Q_W]);
         den_ff[0] <= den;
         lo_ff[0]  <= num[Q_W-1:0];
         q_ff[0]   <= '0;
         ovf_ff[0] <= ROOT_W'(num[NUM_W-1:Q_W]) >= den;
      end
   end

   for (genvar j = 1; j < DIV_LAT; j++) begin : g_step
      logic [ROOT_W:0]   cur;
      logic [ROOT_W-1:0] rem_in;
      logic              bit_in;

      always_comb begin
         cur = {rem_ff[j-1], lo_ff[j-1][Q_W-1]};
         if (cur >= (ROOT_W+1)'(den_ff[j-1])) begin
            rem_in = ROOT_W'(cur - (ROOT_W+1)'(den_ff[j-1]));
            bit_in = 1'b1;
         end else begin
            rem_in = ROOT_W'(cur);
            bit_in = 1'b0;
         end
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            rem_ff[j] <= rem_in;
            den_ff[j] <= den_ff[j-1];
            lo_ff[j]  <= lo_ff[j-1] << 1;
            q_ff[j]   <= {q_ff[j-1][Q_W-2:0], bit_in};
            ovf_ff[j] <= ovf_ff[j-1];
         end
      end
   end

   assign quo = q_ff[DIV_LAT-1];
   assign ovf = ovf_ff[DIV_LAT-1];

endmodule

// ===== hdl/quaternion_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit
//
//  channel  direction  words carried
//  req_     in         tuser: kind; tdata: a_real a_i a_j a_k b_real b_i b_j
//                      b_k scalar
//  rsp_     out        tdata: r_real r_i r_j r_k magnitude status, zero pad
//
//  One word per cycle in and out while the result is not stalled, through the
//  26-stage square root and the 25-stage divider lanes in series.
//  Synchronous active-high reset clears the valid bits only.
//  A stalled result holds the whole pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [qau_pkg::IN_DATA_W-1:0]  req_tdata,  // a_real a_i a_j a_k b_real b_i b_j b_k scalar
   input  logic [qau_pkg::KIND_W-1:0]     req_tuser,  // kind
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [qau_pkg::OUT_DATA_W-1:0] rsp_tdata   // r_real r_i r_j r_k magnitude status
);
   import qau_pkg::*;

   typedef struct packed {
      kind_type                 kind;
      logic [3:0][WORD_W-1:0]   r;
      logic                     sat;
      logic [3:0][WORD_W-1:0]   a;
      logic [WORD_W-1:0]        s;
   } early_type;

   typedef struct packed {
      kind_type                 kind;
      logic [3:0][WORD_W-1:0]   r;
      logic                     sat;
      logic [ROOT_W-1:0]        nm;
      logic                     zero;
      logic [3:0]               neg;
   } late_type;

   localparam logic signed [RND_W-1:0] RND_MAX = RND_W'((2 ** (WORD_W - 1)) - 1);
   localparam logic signed [RND_W-1:0] RND_MIN = -RND_MAX - RND_W'(1);
   localparam logic [SUM_W-1:0]        RND_BIAS = SUM_W'(1) << (FRAC_W - 1);
   localparam logic [WORD_W-1:0]       WMAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic [WORD_W-1:0]       WMIN = {1'b1, {(WORD_W-1){1'b0}}};
   localparam logic [ROOT_W-1:0]       MMAX = ROOT_W'({MAG_W{1'b1}});

   function automatic logic [WORD_W:0] clamp_word(input logic signed [RND_W-1:0] v);
      logic [WORD_W:0] res;
      if (v > RND_MAX) begin
         res = {1'b1, WMAX};
      end else if (v < RND_MIN) begin
         res = {1'b1, WMIN};
      end else begin
         res = {1'b0, v[WORD_W-1:0]};
      end
      return res;
   endfunction

   function automatic logic signed [SUM_W-1:0] ext(input logic signed [PROD_W-1:0] p);
      return {{(SUM_W-PROD_W){p[PROD_W-1]}}, p};
   endfunction

   logic                     ce;
   logic [PIPE_LAT-1:0]      vld_ff;

   // stage 0: input word
   kind_type                 kind0_ff;
   logic signed [WORD_W-1:0] a0_ff [4];
   logic signed [WORD_W-1:0] b0_ff [4];
   logic signed [WORD_W-1:0] s0_ff;

   // stage 1: products
   kind_type                 kind1_ff;
   logic signed [WORD_W-1:0] a1_ff [4];
   logic signed [WORD_W-1:0] s1_ff;
   logic signed [PROD_W-1:0] prod_ff [4][4];
   logic [PROD_W-1:0]        sq_ff [4];
   logic signed [WORD_W:0]   lin_ff [4];

   // stage 2: sums and rounding
   early_type                early_in;
   early_type                early_ff;
   logic [SQ_W-1:0]          ss_ff;
   logic signed [SUM_W-1:0]  sum_in [4];

   logic [ROOT_W-1:0]        root;
   early_type                early_dly_ff [SQRT_LAT];

   // divider preparation
   late_type                 late_in;
   late_type                 late_ff;
   logic [NUM_W-1:0]         num_in [4];
   logic [NUM_W-1:0]         num_ff [4];
   logic [ROOT_W-1:0]        den_in;
   logic [ROOT_W-1:0]        den_ff;
   late_type                 late_dly_ff [DIV_LAT];

   logic [Q_W-1:0]           quo [4];
   logic [3:0]               ovf;

   // result
   logic [3:0][WORD_W-1:0]   r_in;
   logic [MAG_W-1:0]         mag_in;
   status_type               stat_in;
   logic [3:0][WORD_W-1:0]   r_ff;
   logic [MAG_W-1:0]         mag_ff;
   status_type               stat_ff;

   assign ce         = ~rsp_tvalid | rsp_tready;
   assign req_tready = ce;
   assign rsp_tvalid = vld_ff[PIPE_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ce) begin
         vld_ff <= {vld_ff[PIPE_LAT-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         kind0_ff <= kind_type'(req_tuser);
         for (int n = 0; n < 4; n++) begin
            a0_ff[n] <= req_tdata[n*WORD_W +: WORD_W];
            b0_ff[n] <= req_tdata[(n+4)*WORD_W +: WORD_W];
         end
         s0_ff <= req_tdata[8*WORD_W +: WORD_W];
      end
   end

   // scale reuses the first column of the product array
   always_ff @(posedge clock) begin
      if (ce) begin
         kind1_ff <= kind0_ff;
         s1_ff    <= s0_ff;
         for (int x = 0; x < 4; x++) begin
            a1_ff[x] <= a0_ff[x];
            for (int y = 0; y < 4; y++) begin
               if (x == 0 && kind0_ff == KIND_SCALE) begin
                  prod_ff[x][y] <= s0_ff * a0_ff[y];
               end else begin
                  prod_ff[x][y] <= b0_ff[x] * a0_ff[y];
               end
            end
            sq_ff[x] <= PROD_W'(a0_ff[x] * a0_ff[x]);
            case (kind0_ff)
               KIND_ADD:  lin_ff[x] <= (WORD_W+1)'(a0_ff[x]) + (WORD_W+1)'(b0_ff[x]);
               KIND_SUB:  lin_ff[x] <= (WORD_W+1)'(a0_ff[x]) - (WORD_W+1)'(b0_ff[x]);
               KIND_CONJ: begin
                  if (x == 0) begin
                     lin_ff[x] <= (WORD_W+1)'(a0_ff[x]);
                  end else begin
                     lin_ff[x] <= -(WORD_W+1)'(a0_ff[x]);
                  end
               end
               default:   lin_ff[x] <= '0;
            endcase
         end
      end
   end

   always_comb begin
      logic signed [SUM_W-1:0] tot;
      logic signed [RND_W-1:0] v;
      logic [WORD_W:0]         c;
      sum_in[0] = ext(prod_ff[0][0]) - ext(prod_ff[1][1]) - ext(prod_ff[2][2])
                - ext(prod_ff[3][3]);
      sum_in[1] = ext(prod_ff[0][1]) + ext(prod_ff[1][0]) + ext(prod_ff[2][3])
                - ext(prod_ff[3][2]);
      sum_in[2] = ext(prod_ff[0][2]) - ext(prod_ff[1][3]) + ext(prod_ff[2][0])
                + ext(prod_ff[3][1]);
      sum_in[3] = ext(prod_ff[0][3]) + ext(prod_ff[1][2]) - ext(prod_ff[2][1])
                + ext(prod_ff[3][0]);
      early_in.kind = kind1_ff;
      early_in.sat  = 1'b0;
      early_in.s    = s1_ff;
      for (int n = 0; n < 4; n++) begin
         early_in.a[n] = a1_ff[n];
         if (kind1_ff == KIND_SCALE) begin
            tot = ext(prod_ff[0][n]) + $signed(RND_BIAS);
         end else begin
            tot = sum_in[n] + $signed(RND_BIAS);
         end
         case (kind1_ff)
            KIND_MUL, KIND_SCALE:          v = tot[SUM_W-1:FRAC_W];
            KIND_ADD, KIND_SUB, KIND_CONJ: v = RND_W'(lin_ff[n]);
            default:                       v = '0;
         endcase
         c               = clamp_word(v);
         early_in.r[n]   = c[WORD_W-1:0];
         early_in.sat    = early_in.sat | c[WORD_W];
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         early_ff <= early_in;
         ss_ff    <= SQ_W'(sq_ff[0]) + SQ_W'(sq_ff[1]) + SQ_W'(sq_ff[2]) + SQ_W'(sq_ff[3]);
      end
   end

   qau_sqrt u_sqrt (
      .clock (clock),
      .ce    (ce),
      .sq    (ss_ff),
      .root  (root)
   );

   always_ff @(posedge clock) begin
      if (ce) begin
         early_dly_ff[0] <= early_ff;
         for (int i = 1; i < SQRT_LAT; i++) begin
            early_dly_ff[i] <= early_dly_ff[i-1];
         end
      end
   end

   always_comb begin
      early_type             e;
      logic signed [ROOT_W-1:0] sx;
      logic signed [WORD_W:0]   ax;
      logic [WORD_W-1:0]        am;
      e  = early_dly_ff[SQRT_LAT-1];
      sx = ROOT_W'($signed(e.s));
      if (e.kind == KIND_DIV) begin
         den_in = (sx < 0) ? ROOT_W'(-sx) : ROOT_W'(sx);
      end else begin
         den_in = root;
      end
      late_in.kind = e.kind;
      late_in.r    = e.r;
      late_in.sat  = e.sat;
      late_in.nm   = root;
      late_in.zero = (den_in == '0);
      for (int n = 0; n < 4; n++) begin
         ax             = (WORD_W+1)'($signed(e.a[n]));
         am             = (ax < 0) ? WORD_W'(-ax) : WORD_W'(ax);
         num_in[n]      = {am, {FRAC_W{1'b0}}} + NUM_W'(den_in >> 1);
         late_in.neg[n] = e.a[n][WORD_W-1] ^ ((e.kind == KIND_DIV) & e.s[WORD_W-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         late_ff <= late_in;
         den_ff  <= den_in;
         for (int n = 0; n < 4; n++) begin
            num_ff[n] <= num_in[n];
         end
      end
   end

   for (genvar n = 0; n < 4; n++) begin : g_lane
      qau_div_lane u_div (
         .clock (clock),
         .ce    (ce),
         .num   (num_ff[n]),
         .den   (den_ff),
         .quo   (quo[n]),
         .ovf   (ovf[n])
      );
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         late_dly_ff[0] <= late_ff;
         for (int i = 1; i < DIV_LAT; i++) begin
            late_dly_ff[i] <= late_dly_ff[i-1];
         end
      end
   end

   always_comb begin
      late_type l;
      logic     sat;
      l       = late_dly_ff[DIV_LAT-1];
      sat     = l.sat;
      r_in    = l.r;
      mag_in  = '0;
      stat_in = STAT_OK;
      if (l.kind == KIND_DIV || l.kind == KIND_NORMALIZE) begin
         for (int n = 0; n < 4; n++) begin
            if (ovf[n]) begin
               sat     = 1'b1;
               r_in[n] = l.neg[n] ? WMIN : WMAX;
            end else if (l.neg[n]) begin
               if (quo[n] > WMIN) begin
                  sat     = 1'b1;
                  r_in[n] = WMIN;
               end else begin
                  r_in[n] = ~quo[n] + WORD_W'(1);
               end
            end else if (quo[n][Q_W-1]) begin
               sat     = 1'b1;
               r_in[n] = WMAX;
            end else begin
               r_in[n] = quo[n];
            end
         end
      end
      if (l.kind == KIND_NORM) begin
         r_in = '0;
      end
      if (l.kind == KIND_NORMALIZE || l.kind == KIND_NORM) begin
         if (l.nm > MMAX) begin
            sat    = 1'b1;
            mag_in = MMAX[MAG_W-1:0];
         end else begin
            mag_in = l.nm[MAG_W-1:0];
         end
      end
      if (sat) begin
         stat_in = STAT_SAT;
      end
      if ((l.kind == KIND_DIV || l.kind == KIND_NORMALIZE || l.kind == KIND_NORM)
          && l.zero) begin
         r_in    = '0;
         mag_in  = '0;
         stat_in = STAT_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         r_ff    <= r_in;
         mag_ff  <= mag_in;
         stat_ff <= stat_in;
      end
   end

   assign rsp_tdata = OUT_DATA_W'({stat_ff, mag_ff, r_ff});

endmodule

// ===== hdl/qau_checker.sv =====
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module qau_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [qau_pkg::OUT_DATA_W-1:0] rsp_tdata
);
   import qau_pkg::*;

   logic [STAT_W-1:0] stat;
   assign stat = rsp_tdata[4*WORD_W+MAG_W +: STAT_W];

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> stat == STAT_OK || stat == STAT_SAT || stat == STAT_ZERO)
      else $error("undefined status code");

   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && stat == STAT_ZERO |-> rsp_tdata[4*WORD_W+MAG_W-1:0] == '0)
      else $error("zero status with non-zero result");

   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid straight after reset");

endmodule

bind quaternion_arithmetic_unit qau_checker u_qau_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit testbench
// Drives operand words with random gaps, predicts each result in Q3.20 with
// saturation and status, and checks every result word in order.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import qau_pkg::*;

   typedef struct packed {
      logic signed [WORD_W-1:0] r_real;
      logic signed [WORD_W-1:0] r_i;
      logic signed [WORD_W-1:0] r_j;
      logic signed [WORD_W-1:0] r_k;
      logic [MAG_W-1:0]         magnitude;
      status_type               status;
   } qresult_type;

   class qau_scoreboard;
      qresult_type pending[$];
      int          errors;

      static function longint floor_shift(longint v, int s);
         return v >>> s;
      endfunction

      static function longint clamp(longint v, ref bit sat);
         longint hi, lo;
         hi = (longint'(1) <<< (WORD_W - 1)) - 1;
         lo = -hi - 1;
         if (v > hi) begin
            sat = 1;
            return hi;
         end
         if (v < lo) begin
            sat = 1;
            return lo;
         end
         return v;
      endfunction

      static function longint round_prod4(longint t0, longint t1, longint t2, longint t3);
         logic signed [67:0] acc;
         acc = 68'(t0) + 68'(t1) + 68'(t2) + 68'(t3) + (68'sd1 <<< (FRAC_W - 1));
         return longint'(acc >>> FRAC_W);
      endfunction

      static function longint round_quot(longint x, longint d);
         logic [63:0] un, ud, q;
         bit neg;
         neg = (x < 0) != (d < 0);
         un  = (x < 0 ? -x : x) << FRAC_W;
         ud  = d < 0 ? -d : d;
         q   = (un + ud / 2) / ud;
         return neg ? -longint'(q) : longint'(q);
      endfunction

      static function longint root_sum(longint a[4]);
         logic [63:0] s, r, b;
         s = 0;
         r = 0;
         for (int n = 0; n < 4; n++) s += a[n] * a[n];
         b = 64'd1 << 62;
         while (b > s) b >>= 2;
         while (b != 0) begin
            if (s >= r + b) begin
               s -= r + b;
               r  = (r >> 1) + b;
            end else begin
               r >>= 1;
            end
            b >>= 2;
         end
         if (s > r) r++;
         return longint'(r);
      endfunction

      function void note_request(kind_type kind, logic [IN_DATA_W-1:0] data);
         longint a[4], b[4], r[4], s, nm;
         longint mmax;
         bit sat;
         qresult_type res;
         mmax = (longint'(1) <<< MAG_W) - 1;
         for (int n = 0; n < 4; n++) begin
            a[n] = longint'($signed(data[n*WORD_W +: WORD_W]));
            b[n] = longint'($signed(data[(n+4)*WORD_W +: WORD_W]));
            r[n] = 0;
         end
         s   = longint'($signed(data[8*WORD_W +: WORD_W]));
         sat = 0;
         res = '0;
         res.status = STAT_OK;
         case (kind)
            KIND_MUL: begin
               r[0] = round_prod4(b[0]*a[0], -b[1]*a[1], -b[2]*a[2], -b[3]*a[3]);
               r[1] = round_prod4(b[0]*a[1], b[1]*a[0], b[2]*a[3], -b[3]*a[2]);
               r[2] = round_prod4(b[0]*a[2], -b[1]*a[3], b[2]*a[0], b[3]*a[1]);
               r[3] = round_prod4(b[0]*a[3], b[1]*a[2], -b[2]*a[1], b[3]*a[0]);
            end
            KIND_ADD:  for (int n = 0; n < 4; n++) r[n] = a[n] + b[n];
            KIND_SUB:  for (int n = 0; n < 4; n++) r[n] = a[n] - b[n];
            KIND_CONJ: begin
               r[0] = a[0];
               for (int n = 1; n < 4; n++) r[n] = -a[n];
            end
            KIND_SCALE: for (int n = 0; n < 4; n++)
               r[n] = floor_shift(a[n] * s + (longint'(1) <<< (FRAC_W - 1)), FRAC_W);
            KIND_DIV: begin
               if (s == 0) res.status = STAT_ZERO;
               else for (int n = 0; n < 4; n++) r[n] = round_quot(a[n], s);
            end
            default: begin
               nm = root_sum(a);
               if (nm == 0) begin
                  res.status = STAT_ZERO;
               end else begin
                  if (nm > mmax) begin
                     sat = 1;
                     res.magnitude = MAG_W'(mmax);
                  end else begin
                     res.magnitude = MAG_W'(nm);
                  end
                  if (kind == KIND_NORMALIZE)
                     for (int n = 0; n < 4; n++) r[n] = round_quot(a[n], nm);
               end
            end
         endcase
         res.r_real = WORD_W'(clamp(r[0], sat));
         res.r_i    = WORD_W'(clamp(r[1], sat));
         res.r_j    = WORD_W'(clamp(r[2], sat));
         res.r_k    = WORD_W'(clamp(r[3], sat));
         if (res.status == STAT_OK && sat) res.status = STAT_SAT;
         pending.push_back(res);
      endfunction

      function void check_result(logic [OUT_DATA_W-1:0] data);
         qresult_type got, want;
         got.r_real    = data[0 +: WORD_W];
         got.r_i       = data[WORD_W +: WORD_W];
         got.r_j       = data[2*WORD_W +: WORD_W];
         got.r_k       = data[3*WORD_W +: WORD_W];
         got.magnitude = data[4*WORD_W +: MAG_W];
         got.status    = status_type'(data[4*WORD_W+MAG_W +: STAT_W]);
         if (pending.size() == 0) begin
            $error("unexpected result word %h", data);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.r_real !== want.r_real) begin
            $error("r_real expected %0d got %0d", want.r_real, got.r_real);
            errors++;
         end
         if (got.r_i !== want.r_i) begin
            $error("r_i expected %0d got %0d", want.r_i, got.r_i);
            errors++;
         end
         if (got.r_j !== want.r_j) begin
            $error("r_j expected %0d got %0d", want.r_j, got.r_j);
            errors++;
         end
         if (got.r_k !== want.r_k) begin
            $error("r_k expected %0d got %0d", want.r_k, got.r_k);
            errors++;
         end
         if (got.magnitude !== want.magnitude) begin
            $error("magnitude expected %0d got %0d", want.magnitude, got.magnitude);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("status expected %0d got %0d", want.status, got.status);
            errors++;
         end
      endfunction
   endclass

   localparam int WATCHDOG = 20000;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [IN_DATA_W-1:0]  req_tdata;
   logic [KIND_W-1:0]     req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [OUT_DATA_W-1:0] rsp_tdata;

   qau_scoreboard qsb;
   int            send_idle_pct;
   int            stall_pct;
   int            quiet_cycles;

   quaternion_arithmetic_unit dut (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) qsb.note_request(kind_type'(req_tuser), req_tdata);
         if (rsp_tvalid && rsp_tready) qsb.check_result(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG) begin
            $display("quaternion_arithmetic_unit regression: fail");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic logic [WORD_W-1:0] rand_word();
      case ($urandom_range(7))
         0: return {1'b0, {(WORD_W-1){1'b1}}};
         1: return {1'b1, {(WORD_W-1){1'b0}}};
         2: return '0;
         3: return WORD_W'(1 << FRAC_W);
         4: return WORD_W'($signed($urandom_range(2 << FRAC_W)) - (1 << FRAC_W));
         default: return WORD_W'($urandom);
      endcase
   endfunction

   task automatic send_word(kind_type kind, logic [IN_DATA_W-1:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_quat(kind_type kind, logic [WORD_W-1:0] fill);
      send_word(kind, {9{fill}});
   endtask

   task automatic send_random(int count);
      logic [IN_DATA_W-1:0] data;
      for (int i = 0; i < count; i++) begin
         for (int n = 0; n < 9; n++) data[n*WORD_W +: WORD_W] = rand_word();
         send_word(kind_type'($urandom_range(7)), data);
      end
   endtask

   initial begin
      qsb           = new();
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = '0;
      rsp_tready    = 1'b1;
      send_idle_pct = 0;
      stall_pct     = 0;
      quiet_cycles  = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int k = 0; k < 8; k++) begin
         send_quat(kind_type'(k), {1'b0, {(WORD_W-1){1'b1}}});
         send_quat(kind_type'(k), {1'b1, {(WORD_W-1){1'b0}}});
      end
      send_quat(KIND_DIV, '0);
      send_quat(KIND_NORMALIZE, '0);
      send_quat(KIND_NORM, '0);
      send_quat(KIND_MUL, WORD_W'(1 << FRAC_W));
      send_quat(KIND_NORMALIZE, WORD_W'(1));
      send_quat(KIND_SCALE, {WORD_W{1'b1}});

      send_random(190);
      send_idle_pct = 80;
      send_random(180);
      send_idle_pct = 0;
      stall_pct     = 80;
      send_random(190);
      send_idle_pct = 36;
      stall_pct     = 36;
      send_random(190);
      req_tvalid <= 1'b0;

      while (qsb.pending.size() != 0) @(posedge clock);
      repeat (PIPE_LAT + 10) @(posedge clock);
      if (qsb.errors == 0 && qsb.pending.size() == 0) begin
         $display("quaternion_arithmetic_unit regression: pass");
      end else begin
         $display("quaternion_arithmetic_unit regression: fail");
      end
      $finish;
   end
endmodule

// ===== quaternion_arithmetic_unit.f =====
hdl/qau_pkg.sv
hdl/qau_sqrt.sv
hdl/qau_div_lane.sv
hdl/quaternion_arithmetic_unit.sv
hdl/qau_checker.sv
sim/tb.sv
